// File: rtl/rgn_pkg.sv
package rgn_pkg;

	typedef struct packed {
		logic [15:0] block_a;
		logic [15:0] block_b;
		logic [15:0] block_c;
		logic [15:0] block_d;
		logic [1:0]  err_a;
		logic [1:0]  err_b;
		logic [1:0]  err_c;
		logic [1:0]  err_d;
	} rgn_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  group_code;
		logic [15:0] confirmed_pi;
		logic [63:0] ps_name;
		logic [63:0] tmc_provider;
	} rgn_out_t;

	typedef struct packed {
		logic [2:0] name_error_limit;
		logic [2:0] tmc_error_limit;
	} rgn_cfg_t;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_HDR_BAD  = 2'd1;
	localparam logic [1:0] ST_C_BAD    = 2'd2;

	localparam logic [4:0] GRP_0A = 5'd0;
	localparam logic [4:0] GRP_0B = 5'd1;
	localparam logic [4:0] GRP_8A = 5'd16;

	localparam logic [1:0] TMC_SYS_TYPE = 2'd2;
	localparam logic [2:0] TMC_DUR_LO   = 3'd4;
	localparam logic [2:0] TMC_DUR_HI   = 3'd5;

	localparam logic REG_NAME_LIMIT = 1'b0;
	localparam logic REG_TMC_LIMIT  = 1'b1;

	localparam logic [2:0] NAME_LIMIT_RST = 3'd1;
	localparam logic [2:0] TMC_LIMIT_RST  = 3'd2;

endpackage

// File: rtl/rds_group_name_decoder.sv
// RDS group decoder for the program service name and the TMC provider name.
// Group channel (grp_valid / grp_stall / grp): one RDS group per transfer,
// four 16-bit blocks with a 2-bit error level each.
// Result channel (res_valid / res_stall / res): exactly one result per group,
// in order: status, group code, confirmed PI and both 8-character names as
// they stand after the group is applied.
// A group goes through the input register, then the decode and state update
// into the result register. Throughput: one group per cycle while the
// receiver does not stall; the PI, service name and TMC name state is updated
// as the group is taken, so the next group sees it at once.
// When the receiver stalls, the result register holds, the input register
// fills, and grp_stall rises; a new group is taken again as soon as the
// result is transferred, in the same cycle.
// APB port: register 0 (address 0) name error limit, register 1 (address 4)
// TMC error limit, 3 bits each; write only while the block is idle.
// Reset clears both names, both PI registers and the pipeline, and sets the
// limits to 1 and 2.
module rds_group_name_decoder import rgn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        grp_valid,
	output logic        grp_stall,
	input  rgn_in_t     grp,
	output logic        res_valid,
	input  logic        res_stall,
	output rgn_out_t    res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rgn_cfg_t cfg;

	rgn_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic            valid_s1;
	rgn_in_t         grp_s1;
	logic            res_valid_q;
	rgn_out_t        res_q;

	logic [15:0]     conf_q, cand_q;
	logic [0:7][7:0] ps_q, tmc_q;
	logic [15:0]     conf_n, cand_n;
	logic [0:7][7:0] ps_n, tmc_n;
	logic [1:0]      status_n;

	logic            adv, take;
	logic            hdr_ok, c_name_ok, d_name_ok, c_tmc_ok, d_tmc_ok;
	logic [4:0]      code;
	logic [2:0]      seg_idx, tmc_idx;

	assign adv       = ~res_valid_q | ~res_stall;
	assign take      = valid_s1 & adv;
	assign grp_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (~grp_stall) begin
			valid_s1 <= grp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid & ~grp_stall) begin
			grp_s1 <= grp;
		end
	end

	assign code      = grp_s1.block_b[15:11];
	assign hdr_ok    = ({1'b0, grp_s1.err_a} < cfg.name_error_limit) &&
	                   ({1'b0, grp_s1.err_b} < cfg.name_error_limit);
	assign c_name_ok = {1'b0, grp_s1.err_c} < cfg.name_error_limit;
	assign d_name_ok = {1'b0, grp_s1.err_d} < cfg.name_error_limit;
	assign c_tmc_ok  = {1'b0, grp_s1.err_c} < cfg.tmc_error_limit;
	assign d_tmc_ok  = {1'b0, grp_s1.err_d} < cfg.tmc_error_limit;
	assign seg_idx   = {grp_s1.block_b[1:0], 1'b0};
	// base 0 for duration 4, 4 for duration 5
	assign tmc_idx   = {grp_s1.block_b[0], 2'b00};

	always_comb begin
		conf_n   = conf_q;
		cand_n   = cand_q;
		ps_n     = ps_q;
		tmc_n    = tmc_q;
		status_n = ST_ACCEPTED;
		if (!hdr_ok) begin
			status_n = ST_HDR_BAD;
		end else begin
			if (cand_q == grp_s1.block_a) begin
				if (conf_q != cand_q) begin
					ps_n[0] = 8'd0;
				end
				conf_n = cand_q;
			end else begin
				cand_n = grp_s1.block_a;
			end
			if (code == GRP_0A || code == GRP_0B) begin
				if (!c_name_ok) begin
					status_n = ST_C_BAD;
				end else if (d_name_ok) begin
					ps_n[seg_idx]        = grp_s1.block_d[15:8];
					ps_n[seg_idx | 3'd1] = grp_s1.block_d[7:0];
				end
			end else if (code == GRP_8A &&
			             grp_s1.block_b[4:3] == TMC_SYS_TYPE &&
			             (grp_s1.block_b[2:0] == TMC_DUR_LO ||
			              grp_s1.block_b[2:0] == TMC_DUR_HI)) begin
				if (c_tmc_ok) begin
					tmc_n[tmc_idx]         = grp_s1.block_c[15:8];
					tmc_n[tmc_idx | 3'd1]  = grp_s1.block_c[7:0];
				end
				if (d_tmc_ok) begin
					tmc_n[tmc_idx | 3'd2]  = grp_s1.block_d[15:8];
					tmc_n[tmc_idx | 3'd3]  = grp_s1.block_d[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q      <= 16'd0;
			cand_q      <= 16'd0;
			ps_q        <= '0;
			tmc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				conf_q <= conf_n;
				cand_q <= cand_n;
				ps_q   <= ps_n;
				tmc_q  <= tmc_n;
			end
			if (adv) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.status       <= status_n;
			res_q.group_code   <= code;
			res_q.confirmed_pi <= conf_n;
			res_q.ps_name      <= ps_n;
			res_q.tmc_provider <= tmc_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_hdr_bad_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !hdr_ok) |=> ($stable(conf_q) && $stable(cand_q) &&
		                       $stable(ps_q) && $stable(tmc_q)))
		else $error("state changed on a group with an unusable header");

	a_res_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (res_q.confirmed_pi == conf_q && res_q.ps_name == ps_q &&
		          res_q.tmc_provider == tmc_q))
		else $error("result does not show the updated state");

	a_conf_from_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(take && conf_n != conf_q) |=> (conf_q == $past(cand_q)))
		else $error("confirmed PI taken from somewhere other than the candidate");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		grp_stall |-> (valid_s1 && res_valid_q && res_stall))
		else $error("group stalled while the pipeline can advance");

endmodule

// File: rtl/rgn_apb_regs.sv
module rgn_apb_regs import rgn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output rgn_cfg_t    cfg
);

	rgn_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// low address bits only select bytes within a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_error_limit <= NAME_LIMIT_RST;
			cfg_q.tmc_error_limit  <= TMC_LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NAME_LIMIT: cfg_q.name_error_limit <= pwdata[2:0];
				REG_TMC_LIMIT:  cfg_q.tmc_error_limit  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_NAME_LIMIT: prdata = {29'd0, cfg_q.name_error_limit};
			REG_TMC_LIMIT:  prdata = {29'd0, cfg_q.tmc_error_limit};
			default:        prdata = 32'd0;
		endcase
		prdata = prdata | {32{paddr[1] & paddr[0] & 1'b0}};
	end

	assign cfg = cfg_q;

endmodule

// File: tb/tb_rds_group_name_decoder.sv
module tb_rds_group_name_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import rgn_pkg::*;

	localparam logic [4:0] GRP_8B          = 5'd17;
	localparam logic [4:0] GRP_15B         = 5'd31;
	localparam logic [1:0] TMC_OTHER_TYPE  = 2'd1;
	localparam logic [2:0] TMC_DUR_OTHER   = 3'd7;
	localparam int         HOLD_CYCLES     = 80;
	localparam int         MAX_REPORTS     = 10;

	typedef enum int {SHAPE_NAME, SHAPE_TMC, SHAPE_NOISE} shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        grp_valid = 1'b0;
	logic        grp_stall;
	rgn_in_t     grp = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	rgn_out_t    res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rgn_in_t     pending_groups[$];
	rgn_out_t    expected_results[$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          send_hold = 1'b0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	// decoder state as the block should hold it
	logic [2:0]  lim_name = NAME_LIMIT_RST;
	logic [2:0]  lim_tmc = TMC_LIMIT_RST;
	logic [15:0] pi_conf = '0;
	logic [15:0] pi_cand = '0;
	logic [7:0]  ps_chars [8] = '{default: 8'h00};
	logic [7:0]  tmc_chars [8] = '{default: 8'h00};

	rds_group_name_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_stall (grp_stall),
		.grp       (grp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rgn_out_t decode_group(rgn_in_t g);
		rgn_out_t    r;
		logic [4:0]  code;
		logic [2:0]  pos;
		code = g.block_b[15:11];
		r.status = ST_ACCEPTED;
		if (!(g.err_a < lim_name) || !(g.err_b < lim_name)) begin
			r.status = ST_HDR_BAD;
		end else begin
			if (g.block_a == pi_cand) begin
				if (pi_conf != pi_cand)
					ps_chars[0] = 8'h00;
				pi_conf = pi_cand;
			end else begin
				pi_cand = g.block_a;
			end
			if (code == GRP_0A || code == GRP_0B) begin
				if (!(g.err_c < lim_name)) begin
					r.status = ST_C_BAD;
				end else if (g.err_d < lim_name) begin
					pos = {g.block_b[1:0], 1'b0};
					ps_chars[pos]     = g.block_d[15:8];
					ps_chars[pos + 1] = g.block_d[7:0];
				end
			end else if (code == GRP_8A && g.block_b[4:3] == TMC_SYS_TYPE &&
					(g.block_b[2:0] == TMC_DUR_LO || g.block_b[2:0] == TMC_DUR_HI)) begin
				pos = (g.block_b[2:0] == TMC_DUR_LO) ? 3'd0 : 3'd4;
				if (g.err_c < lim_tmc) begin
					tmc_chars[pos]     = g.block_c[15:8];
					tmc_chars[pos + 1] = g.block_c[7:0];
				end
				if (g.err_d < lim_tmc) begin
					tmc_chars[pos + 2] = g.block_d[15:8];
					tmc_chars[pos + 3] = g.block_d[7:0];
				end
			end
		end
		r.group_code = code;
		r.confirmed_pi = pi_conf;
		for (int i = 0; i < 8; i++) begin
			r.ps_name[63 - 8 * i -: 8] = ps_chars[i];
			r.tmc_provider[63 - 8 * i -: 8] = tmc_chars[i];
		end
		return r;
	endfunction

	function automatic rgn_in_t grp_of(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [1:0] ea, logic [1:0] eb, logic [1:0] ec, logic [1:0] ed);
		rgn_in_t g;
		g.block_a = a;
		g.block_b = b;
		g.block_c = c;
		g.block_d = d;
		g.err_a = ea;
		g.err_b = eb;
		g.err_c = ec;
		g.err_d = ed;
		return g;
	endfunction

	// mostly clean blocks, with every level showing up
	function automatic logic [1:0] err_level();
		return ($urandom_range(99) < 60) ? 2'd0 : 2'($urandom_range(3));
	endfunction

	function automatic rgn_in_t random_group(logic [15:0] pi, shape_t shape);
		rgn_in_t g;
		g = grp_of(pi, 16'($urandom), 16'($urandom), 16'($urandom),
			err_level(), err_level(), err_level(), err_level());
		case (shape)
			SHAPE_NAME: begin
				g.block_b[15:11] = $urandom_range(1) ? GRP_0B : GRP_0A;
			end
			SHAPE_TMC: begin
				g.block_b[15:11] = GRP_8A;
				if ($urandom_range(3) != 0)
					g.block_b[4:3] = TMC_SYS_TYPE;
				if ($urandom_range(3) != 0)
					g.block_b[2:0] = $urandom_range(1) ? TMC_DUR_HI : TMC_DUR_LO;
			end
			default: ;
		endcase
		return g;
	endfunction

	// station-like runs: a few PIs repeated, so identifiers get confirmed and names fill
	task automatic queue_random_groups(int count);
		logic [15:0] stations [4];
		logic [15:0] pi;
		int          run;
		int          pick;
		foreach (stations[i])
			stations[i] = 16'($urandom);
		while (count > 0) begin
			pi = ($urandom_range(9) == 0) ? 16'($urandom) : stations[$urandom_range(3)];
			run = $urandom_range(3, 12);
			for (int i = 0; i < run && count > 0; i++) begin
				pick = $urandom_range(99);
				if (pick < 5)
					pending_groups.push_back(random_group(16'($urandom), SHAPE_NOISE));
				else if (pick < 50)
					pending_groups.push_back(random_group(pi, SHAPE_NAME));
				else if (pick < 85)
					pending_groups.push_back(random_group(pi, SHAPE_TMC));
				else
					pending_groups.push_back(random_group(pi, SHAPE_NOISE));
				count--;
			end
		end
	endtask

	task automatic write_limit(logic idx, logic [2:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {29'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== {29'd0, value}) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("register %0d reads %h, wrote %h", idx, prdata, value);
		end
		if (idx == REG_NAME_LIMIT)
			lim_name = value;
		else
			lim_tmc = value;
	endtask

	task automatic wait_drain();
		do
			@(negedge clk);
		while (pending_groups.size() != 0 || grp_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic start_phase(logic [2:0] name_lim, logic [2:0] tmc_lim, int send_pct,
			int stall_p, int count);
		write_limit(REG_NAME_LIMIT, name_lim);
		write_limit(REG_TMC_LIMIT, tmc_lim);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = stall_p;
		queue_random_groups(count);
	endtask

	// sender: present the next group once the current one has transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid <= 1'b0;
		end else begin
			if (grp_valid && !grp_stall)
				expected_results.push_back(decode_group(grp));
			if (!grp_valid || !grp_stall) begin
				if (pending_groups.size() != 0 && !send_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					grp <= pending_groups.pop_front();
					grp_valid <= 1'b1;
				end else begin
					grp_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		rgn_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with nothing pending: %p", res);
			end else begin
				want = expected_results.pop_front();
				if (res.status !== want.status || res.group_code !== want.group_code ||
						res.confirmed_pi !== want.confirmed_pi ||
						res.ps_name !== want.ps_name ||
						res.tmc_provider !== want.tmc_provider) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch exp/got: status %0d/%0d code %0d/%0d pi %h/%h ps %h/%h tmc %h/%h",
							want.status, res.status, want.group_code, res.group_code,
							want.confirmed_pi, res.confirmed_pi, want.ps_name, res.ps_name,
							want.tmc_provider, res.tmc_provider);
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed groups at the reset limits
		pending_groups.push_back(grp_of(16'h0000, {GRP_0A, 11'h000}, 16'h0000, 16'h4142,
			2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			2'd3, 2'd3, 2'd3, 2'd3));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0A, 9'h000, 2'd1}, 16'hAAAA, 16'h4344,
			2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0B, 9'h1FF, 2'd2}, 16'h5555, 16'h4546,
			2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0A, 9'h000, 2'd3}, 16'h0000, 16'h5A5A,
			2'd0, 2'd0, 2'd1, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0B, 9'h000, 2'd3}, 16'h0000, 16'h5B5B,
			2'd0, 2'd0, 2'd0, 2'd2));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0A, 9'h000, 2'd3}, 16'h0000, 16'h4748,
			2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0A, 9'h000, 2'd0}, 16'h0000, 16'h6161,
			2'd1, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_0A, 9'h000, 2'd0}, 16'h0000, 16'h6262,
			2'd0, 2'd2, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_8A, 6'h00, TMC_SYS_TYPE, TMC_DUR_LO},
			16'h5051, 16'h5253, 2'd0, 2'd0, 2'd0, 2'd1));
		pending_groups.push_back(grp_of(16'h1234, {GRP_8A, 6'h3F, TMC_SYS_TYPE, TMC_DUR_HI},
			16'h5455, 16'h5657, 2'd0, 2'd0, 2'd2, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_8A, 6'h15, TMC_SYS_TYPE, TMC_DUR_HI},
			16'h5859, 16'h5A5B, 2'd0, 2'd0, 2'd0, 2'd3));
		pending_groups.push_back(grp_of(16'h1234, {GRP_8A, 6'h3F, TMC_OTHER_TYPE, TMC_DUR_LO},
			16'h7070, 16'h7171, 2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_8A, 6'h00, TMC_SYS_TYPE, TMC_DUR_OTHER},
			16'h7272, 16'h7373, 2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h1234, {GRP_8A, 6'h00, TMC_SYS_TYPE, TMC_DUR_LO},
			16'h7474, 16'h7575, 2'd0, 2'd0, 2'd3, 2'd3));
		pending_groups.push_back(grp_of(16'hBEEF, {GRP_15B, 11'h7FF}, 16'hFFFF, 16'hFFFF,
			2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'hBEEF, {GRP_8B, 6'h00, TMC_SYS_TYPE, TMC_DUR_LO},
			16'h7676, 16'h7777, 2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h0000, {GRP_0A, 9'h000, 2'd0}, 16'h0000, 16'hFFFF,
			2'd0, 2'd0, 2'd0, 2'd0));
		pending_groups.push_back(grp_of(16'h0000, {GRP_0B, 9'h000, 2'd1}, 16'hFFFF, 16'h0000,
			2'd0, 2'd0, 2'd0, 2'd0));
		wait_drain();

		// long receiver hold-off with the sender always offering: fill the pipeline
		start_phase(3'd2, 3'd3, 0, 0, 200);
		hold_reqs++;
		wait_drain();

		// sender pauses midway until every result is back
		start_phase(3'd4, 3'd4, 86, 0, 200);
		do
			@(negedge clk);
		while (pending_groups.size() > 100);
		send_hold = 1'b1;
		do
			@(negedge clk);
		while (grp_valid || expected_results.size() != 0);
		repeat (10) @(negedge clk);
		send_hold = 1'b0;
		wait_drain();

		start_phase(3'd0, 3'd0, 0, 86, 40);
		wait_drain();

		start_phase(3'd3, 3'd1, 0, 86, 180);
		wait_drain();

		start_phase(3'd1, 3'd2, 31, 31, 200);
		wait_drain();

		if (mismatches == 0)
			$display("rds_group_name_decoder test passed");
		else
			$display("rds_group_name_decoder test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("rds_group_name_decoder test failed");
		$finish;
	end

endmodule
